### src/csem_pkg.sv
// Package for the counting semaphore bank: sizes, operation and status codes,
// controller states and the response record.
// No dependencies; every other file of the block imports it.
package csem_pkg;

	// Number of semaphore entries and the width of an entry index.
	localparam int NUM_ENTRIES = 64;
	localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

	// Count and limit width, and the widths of the request and response fields.
	localparam int CNT_W       = 15;
	localparam int OP_W        = 3;
	localparam int ID_W        = 8;
	localparam int START_W     = 16;
	localparam int STATUS_W    = 3;
	localparam int ALLOC_W     = 6;

	// The free-entry search looks at groups of eight entries.
	localparam int GRP_SIZE    = 8;
	localparam int GRP_BIT_W   = $clog2(GRP_SIZE);
	localparam int NUM_GROUPS  = (NUM_ENTRIES + GRP_SIZE - 1) / GRP_SIZE;
	localparam int GRP_W       = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

	// Operation codes; the codes above OP_DOWN mean nothing.
	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 3'd0,
		OP_OPEN  = 3'd1,
		OP_CLOSE = 3'd2,
		OP_UP    = 3'd3,
		OP_DOWN  = 3'd4
	} op_t;

	// Status codes returned with every response.
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK          = 3'd0,
		STAT_BAD_ID      = 3'd1,
		STAT_BAD_COUNT   = 3'd2,
		STAT_CLOSED      = 3'd3,
		STAT_NOT_OPENED  = 3'd4,
		STAT_OVER_LIMIT  = 3'd5,
		STAT_WOULD_BLOCK = 3'd6,
		STAT_NONE_FREE   = 3'd7
	} status_t;

	// Controller states: waiting for a request, or finishing one.
	typedef enum logic {
		FSM_IDLE,
		FSM_EXEC
	} fsm_t;

	// One response as it sits in the output register.
	typedef struct packed {
		logic               ok;
		status_t            status;
		logic [ALLOC_W-1:0] alloc_index;
		logic               wake;
	} rsp_t;

endpackage

### src/csem_if.sv
// Handshake interfaces of the counting semaphore bank: the request channel
// and the response channel. Depends on csem_pkg for the field widths.

interface csem_req_if;
	import csem_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           op;
	logic signed [ID_W-1:0]    sem_id;
	logic signed [START_W-1:0] start_count;

	modport source (output valid, output op, output sem_id, output start_count,
		input ready);
	modport sink (input valid, input op, input sem_id, input start_count,
		output ready);
endinterface

interface csem_rsp_if;
	import csem_pkg::*;

	logic                valid;
	logic                ready;
	logic                ok;
	logic [STATUS_W-1:0] status;
	logic [ALLOC_W-1:0]  alloc_index;
	logic                wake;

	modport source (output valid, output ok, output status, output alloc_index,
		output wake, input ready);
	modport sink (input valid, input ok, input status, input alloc_index,
		input wake, output ready);
endinterface

### src/counting_semaphore_table_top.sv
// Counting semaphore bank: one request in, one response out.
// The response is registered when the request finishes, as soon as the output register
// is free or being emptied. A new request waits until the previous one finishes, since
// the count and limit go through a read-modify-write in a memory with a registered read.
// Reset clears the opened and active flags at once; no clearing pass is needed.
// Depends on csem_pkg and the interfaces in csem_if.sv.
module counting_semaphore_table_top (
	input  logic       clk,
	input  logic       arst_n,
	csem_req_if.sink   req,
	csem_rsp_if.source rsp
);
	import csem_pkg::*;

	localparam int PAD_W = NUM_GROUPS * GRP_SIZE;

	// Count and limit per entry, packed as {count, limit}.
	logic [2*CNT_W-1:0] cnt_mem [NUM_ENTRIES];
	logic [2*CNT_W-1:0] cnt_rd_q;

	// Per-entry flags in flip-flops, cleared by reset.
	logic [NUM_ENTRIES-1:0] opened_q;
	logic [NUM_ENTRIES-1:0] active_q;

	// Captured request.
	logic [OP_W-1:0]  op_q;
	logic [IDX_W-1:0] idx_q;
	logic             id_ok_q;
	logic [CNT_W-1:0] start_q;
	logic             start_neg_q;

	// First level of the free-entry search, registered at accept.
	logic [NUM_GROUPS-1:0]                grp_any_q;
	logic [NUM_GROUPS-1:0][GRP_BIT_W-1:0] grp_first_q;

	fsm_t state_q, state_d;
	logic accept;
	logic exec_done;

	rsp_t rsp_q;
	logic rsp_valid_q;

	// Decoded request fields.
	logic [IDX_W-1:0] req_idx;
	logic             req_id_ok;

	assign req_idx   = IDX_W'({{IDX_W{1'b0}}, req.sem_id[ID_W-2:0]});
	assign req_id_ok = !req.sem_id[ID_W-1]
		&& (32'(req.sem_id[ID_W-2:0]) < 32'(NUM_ENTRIES));

	// Controller state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: a request is accepted when idle, and finishes as soon as the
	// output register is free or being emptied.
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		exec_done = 1'b0;
		unique case (state_q)
			FSM_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				if (!rsp_valid_q || rsp.ready) begin
					exec_done = 1'b1;
					state_d   = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	assign accept = req.valid && req.ready;

	// Capture the request fields.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= req.op;
			idx_q       <= req_idx;
			id_ok_q     <= req_id_ok;
			start_q     <= req.start_count[CNT_W-1:0];
			start_neg_q <= req.start_count[START_W-1];
		end
	end

	// Per-group first free entry; padding past the last entry never counts as free.
	logic [PAD_W-1:0]                     free_pad;
	logic [NUM_GROUPS-1:0]                grp_any_d;
	logic [NUM_GROUPS-1:0][GRP_BIT_W-1:0] grp_first_d;

	assign free_pad = PAD_W'(~active_q);

	always_comb begin
		for (int g = 0; g < NUM_GROUPS; g++) begin
			grp_any_d[g]   = 1'b0;
			grp_first_d[g] = '0;
			for (int b = GRP_SIZE - 1; b >= 0; b--) begin
				if (free_pad[g*GRP_SIZE + b]) begin
					grp_any_d[g]   = 1'b1;
					grp_first_d[g] = GRP_BIT_W'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			grp_any_q   <= grp_any_d;
			grp_first_q <= grp_first_d;
		end
	end

	// Second level of the search: the lowest group that holds a free entry.
	logic             free_found;
	logic [GRP_W-1:0] free_grp;
	logic [IDX_W-1:0] free_idx;

	always_comb begin
		free_found = 1'b0;
		free_grp   = '0;
		for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
			if (grp_any_q[g]) begin
				free_found = 1'b1;
				free_grp   = GRP_W'(g);
			end
		end
	end

	assign free_idx = IDX_W'({free_grp, grp_first_q[free_grp]});

	// Decide the response and the write-back for the captured request.
	logic [CNT_W-1:0]   cur_cnt;
	logic [CNT_W-1:0]   cur_lim;
	logic               cur_open;
	logic               cur_act;
	status_t            res_status;
	logic [IDX_W-1:0]   res_idx;
	logic               res_wake;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_wa;
	logic [2*CNT_W-1:0] mem_wd;
	logic               flag_we;
	logic [IDX_W-1:0]   flag_idx;
	logic               open_d;
	logic               act_d;

	assign cur_cnt  = cnt_rd_q[2*CNT_W-1:CNT_W];
	assign cur_lim  = cnt_rd_q[CNT_W-1:0];
	assign cur_open = opened_q[idx_q];
	assign cur_act  = active_q[idx_q];

	always_comb begin
		res_status = STAT_OK;
		res_idx    = '0;
		res_wake   = 1'b0;
		mem_we     = 1'b0;
		mem_wa     = idx_q;
		mem_wd     = cnt_rd_q;
		flag_we    = 1'b0;
		flag_idx   = idx_q;
		open_d     = cur_open;
		act_d      = cur_act;
		priority if (op_q == OP_ALLOC) begin
			if (free_found) begin
				mem_we   = 1'b1;
				mem_wa   = free_idx;
				mem_wd   = '0;
				flag_we  = 1'b1;
				flag_idx = free_idx;
				open_d   = 1'b1;
				act_d    = 1'b1;
				res_idx  = free_idx;
			end else begin
				res_status = STAT_NONE_FREE;
			end
		end else if (op_q > OP_DOWN || !id_ok_q) begin
			res_status = STAT_BAD_ID;
		end else begin
			unique case (op_q)
				OP_OPEN: begin
					if (start_neg_q) begin
						res_status = STAT_BAD_COUNT;
					end else begin
						mem_we  = 1'b1;
						mem_wd  = {start_q, start_q};
						flag_we = 1'b1;
						open_d  = 1'b1;
					end
				end
				OP_CLOSE: begin
					if (!cur_open) begin
						res_status = STAT_NOT_OPENED;
					end else if (cur_cnt > cur_lim) begin
						res_status = STAT_OVER_LIMIT;
					end else begin
						flag_we = 1'b1;
						open_d  = 1'b0;
						act_d   = 1'b0;
					end
				end
				OP_UP: begin
					if (!cur_act) begin
						res_status = STAT_CLOSED;
					end else if (!cur_open) begin
						res_status = STAT_NOT_OPENED;
					end else if (cur_cnt >= cur_lim) begin
						res_status = STAT_OVER_LIMIT;
					end else begin
						mem_we   = 1'b1;
						mem_wd   = {cur_cnt + CNT_W'(1), cur_lim};
						res_wake = 1'b1;
					end
				end
				default: begin
					if (!cur_act) begin
						res_status = STAT_CLOSED;
					end else if (!cur_open) begin
						res_status = STAT_NOT_OPENED;
					end else if (cur_cnt == '0) begin
						res_status = STAT_WOULD_BLOCK;
					end else begin
						mem_we = 1'b1;
						mem_wd = {cur_cnt - CNT_W'(1), cur_lim};
					end
				end
			endcase
		end
	end

	// Count and limit memory: read at accept, written when the request finishes.
	// The controller never reads and writes in the same cycle, so no forwarding.
	always_ff @(posedge clk) begin
		if (exec_done && mem_we) begin
			cnt_mem[mem_wa] <= mem_wd;
		end
		if (accept) begin
			cnt_rd_q <= cnt_mem[req_idx];
		end
	end

	// Flag update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opened_q <= '0;
			active_q <= '0;
		end else if (exec_done && flag_we) begin
			opened_q[flag_idx] <= open_d;
			active_q[flag_idx] <= act_d;
		end
	end

	// Output register: loaded when a request finishes, emptied by the sink.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec_done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_done) begin
			rsp_q.ok          <= (res_status == STAT_OK);
			rsp_q.status      <= res_status;
			rsp_q.alloc_index <= ALLOC_W'(res_idx);
			rsp_q.wake        <= res_wake;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.ok          = rsp_q.ok;
	assign rsp.status      = rsp_q.status;
	assign rsp.alloc_index = rsp_q.alloc_index;
	assign rsp.wake        = rsp_q.wake;

	// A new response appears only when a request finishes.
	a_rsp_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == FSM_EXEC)
		else $error("response appeared without a finishing request");

	// A wake is only given with a successful response.
	a_wake_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.wake |-> rsp.ok && rsp.status == STAT_OK)
		else $error("wake without success");

	// A successful allocate leaves the claimed entry active and opened.
	a_alloc_sets: assert property (@(posedge clk) disable iff (!arst_n)
		exec_done && op_q == OP_ALLOC && free_found
		|=> active_q[$past(free_idx)] && opened_q[$past(free_idx)])
		else $error("allocated entry not marked active");

	// A request is not accepted while another one is still being finished.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q == FSM_EXEC && !req.ready)
		else $error("request accepted during execution");

endmodule

### tb/counting_semaphore_table_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the counting semaphore bank: a directed table, then random
// requests, each checked against its written-out response or a model of the entry table.
// Depends on csem_pkg, the interfaces in csem_if.sv and counting_semaphore_table_top.
module counting_semaphore_table_top_test;
	import csem_pkg::*;

	// Op codes the block does not define; they must be rejected as a bad id.
	localparam logic [OP_W-1:0] OP_UNUSED_5 = OP_W'(5);
	localparam logic [OP_W-1:0] OP_UNUSED_6 = OP_W'(6);
	localparam logic [OP_W-1:0] OP_UNUSED_7 = OP_W'(7);

	localparam int NUM_DIRECTED = 25;
	localparam int RANDOM_REQUESTS = 540;
	localparam int MAX_WAIT = 12;

	// One row of the directed table; checked rows carry a hand-written response.
	typedef struct {
		logic [OP_W-1:0]           op;
		logic signed [ID_W-1:0]    id;
		logic signed [START_W-1:0] cnt;
		bit                        checked;
		status_t                   st;
		logic [ALLOC_W-1:0]        idx;
		logic                      wake;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	csem_req_if req_ch ();
	csem_rsp_if rsp_ch ();

	counting_semaphore_table_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Model of the entry table.
	logic [CNT_W-1:0] sem_count [NUM_ENTRIES];
	logic [CNT_W-1:0] sem_limit [NUM_ENTRIES];
	bit               sem_opened [NUM_ENTRIES];
	bit               sem_active [NUM_ENTRIES];

	rsp_t expected_rsp [$];
	rsp_t next_rsp;
	bit   hand_checked;
	rsp_t hand_rsp;
	bit   quiet_stretch;
	int   error_count;

	stim_row_t directed_rows [NUM_DIRECTED] = '{
		'{OP_UP,       8'sd0,   16'sd0,     1'b1, STAT_CLOSED,      6'd0, 1'b0},
		'{OP_CLOSE,    8'sd0,   16'sd0,     1'b1, STAT_NOT_OPENED,  6'd0, 1'b0},
		'{OP_DOWN,     8'sd63,  16'sd0,     1'b1, STAT_CLOSED,      6'd0, 1'b0},
		'{OP_OPEN,     8'sh80,  16'sd5,     1'b1, STAT_BAD_ID,      6'd0, 1'b0},
		'{OP_OPEN,     8'sd64,  16'sd5,     1'b1, STAT_BAD_ID,      6'd0, 1'b0},
		'{OP_OPEN,     8'sd127, 16'shFFFF,  1'b1, STAT_BAD_ID,      6'd0, 1'b0},
		'{OP_OPEN,     8'sd5,   16'sh8000,  1'b1, STAT_BAD_COUNT,   6'd0, 1'b0},
		'{OP_UNUSED_5, 8'sd0,   16'sd1,     1'b1, STAT_BAD_ID,      6'd0, 1'b0},
		'{OP_UNUSED_6, 8'sd3,   16'sd0,     1'b1, STAT_BAD_ID,      6'd0, 1'b0},
		'{OP_UNUSED_7, 8'shFF,  16'sh7FFF,  1'b1, STAT_BAD_ID,      6'd0, 1'b0},
		'{OP_ALLOC,    8'sd0,   16'sd0,     1'b1, STAT_OK,          6'd0, 1'b0},
		'{OP_ALLOC,    8'sd9,   16'sd3,     1'b1, STAT_OK,          6'd1, 1'b0},
		'{OP_DOWN,     8'sd0,   16'sd0,     1'b1, STAT_WOULD_BLOCK, 6'd0, 1'b0},
		'{OP_UP,       8'sd0,   16'sd0,     1'b1, STAT_OVER_LIMIT,  6'd0, 1'b0},
		'{OP_OPEN,     8'sd0,   16'sh7FFF,  1'b1, STAT_OK,          6'd0, 1'b0},
		'{OP_UP,       8'sd0,   16'sd0,     1'b1, STAT_OVER_LIMIT,  6'd0, 1'b0},
		'{OP_DOWN,     8'sd0,   16'sd0,     1'b1, STAT_OK,          6'd0, 1'b0},
		'{OP_UP,       8'sd0,   16'sd0,     1'b1, STAT_OK,          6'd0, 1'b1},
		'{OP_ALLOC,    8'shFF,  16'shFFFF,  1'b1, STAT_OK,          6'd2, 1'b0},
		'{OP_OPEN,     8'sd63,  16'sd1,     1'b0, STAT_OK,          6'd0, 1'b0},
		'{OP_UP,       8'sd63,  16'sd0,     1'b1, STAT_CLOSED,      6'd0, 1'b0},
		'{OP_CLOSE,    8'sd63,  16'sd0,     1'b0, STAT_OK,          6'd0, 1'b0},
		'{OP_CLOSE,    8'sd1,   16'sd0,     1'b0, STAT_OK,          6'd0, 1'b0},
		'{OP_ALLOC,    8'sd127, 16'sh8000,  1'b0, STAT_OK,          6'd0, 1'b0},
		'{OP_DOWN,     8'sd2,   16'sd0,     1'b0, STAT_OK,          6'd0, 1'b0}
	};

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Prints one line per failure and counts it.
	task automatic report_error(string msg);
		$display("[%0t] ERROR: %s", $time, msg);
		error_count++;
	endtask

	// Applies one request to the entry table and returns the response it should produce.
	function automatic rsp_t semaphore_apply(logic [OP_W-1:0] op, logic signed [ID_W-1:0] id,
		logic signed [START_W-1:0] cnt);
		rsp_t r;
		int   e;
		bit   id_ok;
		r.ok = 1'b0;
		r.status = STAT_OK;
		r.alloc_index = '0;
		r.wake = 1'b0;
		id_ok = (id >= 0) && (int'(id) < NUM_ENTRIES);
		e = id_ok ? int'(id) : 0;
		if (op == OP_ALLOC) begin
			// Claim the lowest inactive entry; the id field plays no part.
			r.status = STAT_NONE_FREE;
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				if (!sem_active[i]) begin
					sem_count[i] = '0;
					sem_limit[i] = '0;
					sem_opened[i] = 1'b1;
					sem_active[i] = 1'b1;
					r.status = STAT_OK;
					r.alloc_index = ALLOC_W'(i);
					break;
				end
			end
		end else if (op > OP_DOWN || !id_ok) begin
			r.status = STAT_BAD_ID;
		end else begin
			case (op)
				OP_OPEN: begin
					if (cnt < 0) begin
						r.status = STAT_BAD_COUNT;
					end else begin
						sem_count[e] = cnt[CNT_W-1:0];
						sem_limit[e] = cnt[CNT_W-1:0];
						sem_opened[e] = 1'b1;
					end
				end
				OP_CLOSE: begin
					if (!sem_opened[e]) begin
						r.status = STAT_NOT_OPENED;
					end else if (sem_count[e] > sem_limit[e]) begin
						r.status = STAT_OVER_LIMIT;
					end else begin
						sem_count[e] = '0;
						sem_limit[e] = '0;
						sem_opened[e] = 1'b0;
						sem_active[e] = 1'b0;
					end
				end
				OP_UP: begin
					if (!sem_active[e]) begin
						r.status = STAT_CLOSED;
					end else if (!sem_opened[e]) begin
						r.status = STAT_NOT_OPENED;
					end else if (sem_count[e] >= sem_limit[e]) begin
						r.status = STAT_OVER_LIMIT;
					end else begin
						sem_count[e] = sem_count[e] + 1'b1;
						r.wake = 1'b1;
					end
				end
				default: begin
					if (!sem_active[e]) begin
						r.status = STAT_CLOSED;
					end else if (!sem_opened[e]) begin
						r.status = STAT_NOT_OPENED;
					end else if (sem_count[e] == '0) begin
						r.status = STAT_WOULD_BLOCK;
					end else begin
						sem_count[e] = sem_count[e] - 1'b1;
					end
				end
			endcase
		end
		r.ok = (r.status == STAT_OK);
		return r;
	endfunction

	// Monitor: checks each accepted response, then records the one a newly accepted
	// request should produce.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsp.size() == 0) begin
					report_error("response with no request outstanding");
				end else begin
					next_rsp = expected_rsp.pop_front();
					if (rsp_ch.ok !== next_rsp.ok)
						report_error($sformatf("ok: got %b, expected %b",
							rsp_ch.ok, next_rsp.ok));
					if (rsp_ch.status !== next_rsp.status)
						report_error($sformatf("status: got %0d, expected %0d",
							rsp_ch.status, next_rsp.status));
					if (rsp_ch.alloc_index !== next_rsp.alloc_index)
						report_error($sformatf("alloc_index: got %0d, expected %0d",
							rsp_ch.alloc_index, next_rsp.alloc_index));
					if (rsp_ch.wake !== next_rsp.wake)
						report_error($sformatf("wake: got %b, expected %b",
							rsp_ch.wake, next_rsp.wake));
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				next_rsp = semaphore_apply(req_ch.op, req_ch.sem_id, req_ch.start_count);
				// Table rows with a written-out response are held to that value.
				if (hand_checked) begin
					next_rsp = hand_rsp;
				end
				expected_rsp.push_back(next_rsp);
			end
		end
	end

	// Sends one request after a random gap, none in a quiet stretch, and returns once it is
	// accepted. Valid stays high on return so that a back-to-back request needs no toggle.
	task automatic send_request(logic [OP_W-1:0] op, logic signed [ID_W-1:0] id,
		logic signed [START_W-1:0] cnt, bit checked, rsp_t want);
		int gap;
		gap = quiet_stretch ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.sem_id <= id;
		req_ch.start_count <= cnt;
		hand_checked = checked;
		hand_rsp = want;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Draws a request that mostly works on a few low entries with small counts.
	task automatic draw_request(output logic [OP_W-1:0] op, output logic signed [ID_W-1:0] id,
		output logic signed [START_W-1:0] cnt);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 14) op = OP_ALLOC;
		else if (pick < 32) op = OP_OPEN;
		else if (pick < 44) op = OP_CLOSE;
		else if (pick < 68) op = OP_UP;
		else if (pick < 92) op = OP_DOWN;
		else op = OP_W'($urandom_range(int'(OP_UNUSED_5), int'(OP_UNUSED_7)));
		pick = $urandom_range(0, 99);
		if (pick < 80) id = ID_W'($urandom_range(0, 7));
		else if (pick < 88) id = ID_W'($urandom_range(NUM_ENTRIES - 8, NUM_ENTRIES - 1));
		else id = ID_W'($urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		if (pick < 55) cnt = START_W'($urandom_range(0, 3));
		else if (pick < 75) cnt = START_W'($urandom_range(0, 32767));
		else if (pick < 82) cnt = 16'sh7FFF;
		else cnt = START_W'($urandom_range(32768, 65535));
	endtask

	// Lowers valid and holds off until every outstanding response has come back.
	task automatic drain_responses();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (expected_rsp.size() != 0) @(negedge clk);
	endtask

	// Response side: random stall before each response, none during quiet stretches.
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = quiet_stretch ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				@(negedge clk);
				rsp_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
		end
	end

	// Stimulus: reset, directed table, random requests with table-filling bursts.
	initial begin
		rsp_t                      want;
		logic [OP_W-1:0]           op;
		logic signed [ID_W-1:0]    id;
		logic signed [START_W-1:0] cnt;
		int                        sent;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_ALLOC;
		req_ch.sem_id = '0;
		req_ch.start_count = '0;
		hand_checked = 1'b0;
		hand_rsp = '0;
		quiet_stretch = 1'b0;
		error_count = 0;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			sem_count[i] = '0;
			sem_limit[i] = '0;
			sem_opened[i] = 1'b0;
			sem_active[i] = 1'b0;
		end
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Directed table.
		foreach (directed_rows[i]) begin
			want.ok = (directed_rows[i].st == STAT_OK);
			want.status = directed_rows[i].st;
			want.alloc_index = directed_rows[i].idx;
			want.wake = directed_rows[i].wake;
			send_request(directed_rows[i].op, directed_rows[i].id, directed_rows[i].cnt,
				directed_rows[i].checked, want);
		end

		// Random requests; every fourth stretch of 40 runs with no idling on either side.
		want = '0;
		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			quiet_stretch = ((sent / 40) % 4) == 3;
			if (sent == 300) begin
				drain_responses();
			end
			if (sent == 150 || sent == 420) begin
				// Fill the whole table, run past it, then free about half the entries.
				repeat (NUM_ENTRIES + 2) begin
					send_request(OP_ALLOC, ID_W'($urandom_range(0, 255)),
						START_W'($urandom_range(0, 65535)), 1'b0, want);
				end
				repeat (NUM_ENTRIES / 2) begin
					send_request(OP_CLOSE, ID_W'($urandom_range(0, NUM_ENTRIES - 1)),
						START_W'($urandom_range(0, 65535)), 1'b0, want);
				end
				sent += NUM_ENTRIES + 2 + NUM_ENTRIES / 2;
			end else begin
				draw_request(op, id, cnt);
				send_request(op, id, cnt, 1'b0, want);
				sent++;
			end
		end
		quiet_stretch = 1'b0;

		// Let the last responses come back, then a few more cycles for strays.
		drain_responses();
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#1_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### counting_semaphore_table_top.f
src/csem_pkg.sv
src/csem_if.sv
src/counting_semaphore_table_top.sv
tb/counting_semaphore_table_top_test.sv
